// File: src/mrffe_pkg.sv
// shared types and constants for the mono rectangle and frame fill engine
package mrffe_pkg;

   localparam int STORE_DEPTH  = 65536;
   localparam int STORE_ADDR_W = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;

   localparam logic [7:0] BYTE_WHITE = 8'hFF;
   localparam logic [7:0] BYTE_NONE  = 8'h00;

   typedef enum logic [1:0] {
      CMD_FILL  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_BOX,
      OP_READ,
      OP_CLEAR
   } op_kind_type;

   typedef enum logic {
      FR_IDLE,
      FR_EMIT
   } front_state_type;

   typedef enum logic [3:0] {
      BK_INIT,
      BK_IDLE,
      BK_SETUP,
      BK_RD,
      BK_WR,
      BK_RDB,
      BK_RDW,
      BK_CLR,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [11:0]        rect_width;
      logic [11:0]        rect_height;
      logic [7:0]         band_thickness;
      logic               paint_white;
      logic [15:0]        byte_index;
      logic [7:0]         clear_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       painted_any;
   } rsp_type;

   // one unit of work for the back end: a clipped box, a byte read or a clear sweep
   typedef struct packed {
      op_kind_type kind;
      logic        live;
      logic        last;
      logic        any;
      logic        white;
      logic [11:0] x0;
      logic [11:0] x1;
      logic [11:0] y0;
      logic [11:0] y1;
      logic [15:0] idx;
      logic [7:0]  clr;
   } op_type;

   typedef struct packed {
      logic push;
   } queue_wr_type;

endpackage

// File: src/mrffe_ram.sv
// generic single write port, single read port ram with registered read
module mrffe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mrffe_front.sv
// front end: takes commands, splits frames into bands, clips each box to the panel
module mrffe_front import mrffe_pkg::*; #(
   parameter int PANEL_WIDTH  = 1024,
   parameter int PANEL_HEIGHT = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req,
   input  logic         init_busy,
   output queue_wr_type q_wr,
   input  logic         q_full,
   output op_type       q_op
);

   localparam logic signed [14:0] PW_S = 15'(PANEL_WIDTH);
   localparam logic signed [14:0] PH_S = 15'(PANEL_HEIGHT);

   front_state_type state_ff, state_in;
   logic [1:0]      band_ff, band_in;
   logic            any_ff, any_in;
   req_type         item_ff, item_in;

   logic signed [14:0] xs, ys, ws, hs, ts;
   logic signed [14:0] bx, by, bw, bh;
   logic signed [14:0] xe, ye, x0c, x1c, y0c, y1c;
   logic               size_ok, box_live, is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         band_ff  <= '0;
         any_ff   <= 1'b0;
         item_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         any_ff   <= any_in;
         item_ff  <= item_in;
      end
   end

   // band geometry and clipping
   always_comb begin
      xs = {{3{item_ff.pos_x[11]}}, item_ff.pos_x};
      ys = {{3{item_ff.pos_y[11]}}, item_ff.pos_y};
      ws = {3'b000, item_ff.rect_width};
      hs = {3'b000, item_ff.rect_height};
      ts = {7'b0000000, item_ff.band_thickness};
      bx = xs;
      by = ys;
      bw = ws;
      bh = hs;
      unique case (item_ff.cmd)
         CMD_FRAME: begin
            unique case (band_ff)
               2'd0: begin
                  bh = ts;
               end
               2'd1: begin
                  by = ys + hs - ts;
                  bh = ts;
               end
               2'd2: begin
                  bw = ts;
               end
               2'd3: begin
                  bx = xs + ws - ts;
                  bw = ts;
               end
            endcase
         end
         CMD_FILL, CMD_READ, CMD_CLEAR: begin
         end
      endcase
      xe  = bx + bw;
      ye  = by + bh;
      x0c = (bx < 15'sd0) ? 15'sd0 : bx;
      y0c = (by < 15'sd0) ? 15'sd0 : by;
      x1c = (xe > PW_S) ? PW_S : xe;
      y1c = (ye > PH_S) ? PH_S : ye;
      size_ok  = (item_ff.rect_width != '0) && (item_ff.rect_height != '0);
      box_live = size_ok && (bw != 15'sd0) && (bh != 15'sd0) && (x0c < x1c) && (y0c < y1c);
      is_last  = (item_ff.cmd == CMD_FRAME) ? (band_ff == '1) : 1'b1;
   end

   always_comb begin
      q_op.kind  = OP_BOX;
      unique case (item_ff.cmd)
         CMD_FILL, CMD_FRAME: q_op.kind = OP_BOX;
         CMD_READ:            q_op.kind = OP_READ;
         CMD_CLEAR:           q_op.kind = OP_CLEAR;
      endcase
      q_op.live  = box_live;
      q_op.last  = is_last;
      q_op.any   = any_ff | box_live;
      q_op.white = item_ff.paint_white;
      q_op.x0    = x0c[11:0];
      q_op.x1    = x1c[11:0];
      q_op.y0    = y0c[11:0];
      q_op.y1    = y1c[11:0];
      q_op.idx   = item_ff.byte_index;
      q_op.clr   = item_ff.clear_value;
   end

   always_comb begin
      state_in  = state_ff;
      band_in   = band_ff;
      any_in    = any_ff;
      item_in   = item_ff;
      q_wr.push = 1'b0;
      req_stall = (state_ff != FR_IDLE) || init_busy;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_valid && !req_stall) begin
               item_in  = req;
               band_in  = '0;
               any_in   = 1'b0;
               state_in = FR_EMIT;
            end
         end
         FR_EMIT: begin
            if (!q_full) begin
               q_wr.push = 1'b1;
               any_in    = any_ff | box_live;
               band_in   = band_ff + 2'd1;
               if (is_last) begin
                  state_in = FR_IDLE;
               end
            end
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_stall_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall)
      else $error("command taken during store initialization");
`endif

endmodule

// File: src/mrffe_queue.sv
// short op queue between front and back end
module mrffe_queue import mrffe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type q_wr,
   input  op_type       wr_op,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output op_type       head
);

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(q_wr.push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + (QUEUE_PTR_W+1)'(q_wr.push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= wr_op;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !full || pop)
      else $error("op pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("op popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// File: src/mrffe_back.sv
// back end: read-modify-write walk over boxes, byte reads, clear sweeps, result register
module mrffe_back import mrffe_pkg::*; #(
   parameter int PANEL_WIDTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  op_type  q_head,
   output logic    q_pop,
   output logic    init_busy,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int PITCH = PANEL_WIDTH / 8;

   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [11:0]    row_ff, row_in;
   logic [15:0]    base_ff, base_in;
   logic [7:0]     col_ff, col_in;
   logic [15:0]    sweep_ff, sweep_in;
   logic [7:0]     rdbyte_ff, rdbyte_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic                    wr_en, rd_en;
   logic [STORE_ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]              wr_data, rd_data;

   logic [11:0] x1m1, y1m1;
   logic [7:0]  col_first, col_last, mask, lo_mask, hi_mask;
   logic [15:0] addr;
   logic [27:0] base_prod;
   logic        slot_free;

   mrffe_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      row_ff    <= row_in;
      base_ff   <= base_in;
      col_ff    <= col_in;
      rdbyte_ff <= rdbyte_in;
      rsp_ff    <= rsp_in;
   end

   // byte walk geometry
   always_comb begin
      x1m1      = op_ff.x1 - 12'd1;
      y1m1      = op_ff.y1 - 12'd1;
      col_first = op_ff.x0[10:3];
      col_last  = x1m1[10:3];
      lo_mask   = (col_ff == col_first) ? (8'hFF >> op_ff.x0[2:0]) : 8'hFF;
      hi_mask   = (col_ff == col_last) ? (8'hFF << (3'd7 - x1m1[2:0])) : 8'hFF;
      mask      = lo_mask & hi_mask;
      addr      = base_ff + {8'b0, col_ff};
      base_prod = 28'(op_ff.y0) * 28'(PITCH);
      slot_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      rdbyte_in    = rdbyte_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr;
      wr_data      = op_ff.white ? (rd_data | mask) : (rd_data & ~mask);
      rd_en        = 1'b0;
      rd_addr      = addr;
      init_busy    = (state_ff == BK_INIT);
      unique case (state_ff)
         BK_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = BYTE_WHITE;
            sweep_in = sweep_ff + 16'd1;
            if (sweep_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               op_in = q_head;
               unique case (q_head.kind)
                  OP_BOX: begin
                     if (q_head.live) begin
                        state_in = BK_SETUP;
                     end else if (q_head.last) begin
                        state_in = BK_FIN;
                     end
                  end
                  OP_READ: state_in = BK_RDB;
                  OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = BK_CLR;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_SETUP: begin
            row_in   = op_ff.y0;
            base_in  = base_prod[15:0];
            col_in   = col_first;
            state_in = BK_RD;
         end
         BK_RD: begin
            rd_en    = 1'b1;
            state_in = BK_WR;
         end
         BK_WR: begin
            wr_en    = 1'b1;
            state_in = BK_RD;
            if (col_ff != col_last) begin
               col_in = col_ff + 8'd1;
            end else if (row_ff != y1m1) begin
               row_in  = row_ff + 12'd1;
               base_in = base_ff + 16'(PITCH);
               col_in  = col_first;
            end else begin
               state_in = op_ff.last ? BK_FIN : BK_IDLE;
            end
         end
         BK_RDB: begin
            rd_en    = 1'b1;
            rd_addr  = op_ff.idx;
            state_in = BK_RDW;
         end
         BK_RDW: begin
            rdbyte_in = rd_data;
            state_in  = BK_FIN;
         end
         BK_CLR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = op_ff.clr;
            sweep_in = sweep_ff + 16'd1;
            if (sweep_ff == '1) begin
               state_in = op_ff.last ? BK_FIN : BK_IDLE;
            end
         end
         BK_FIN: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_byte   = (op_ff.kind == OP_READ) ? rdbyte_ff : BYTE_NONE;
               rsp_in.painted_any = (op_ff.kind == OP_BOX) && op_ff.any;
               state_in           = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WR) |-> ($past(state_ff) == BK_RD))
      else $error("byte written back without a read before it");
`endif

endmodule

// File: src/mono_rect_frame_fill_engine_core.sv
// top level of the mono rectangle and frame fill engine over a 1-bit framebuffer
//
//  channel   dir   handshake             payload
//  req_      in    req_valid / req_stall req_type  (one command)
//  rsp_      out   rsp_valid / rsp_stall rsp_type  (read byte, painted flag)
//
// after reset the store is swept to white, one byte a cycle, with req_stall high throughout
// fill: each covered byte is read, then written back
// frame: up to four such boxes in turn; read byte: one registered read; clear: sweep of all 65536 bytes
// the store has a single read and a single write port
// the front end keeps taking commands while the back end works or a result waits on rsp_stall, until the op queue fills
module mono_rect_frame_fill_engine_core import mrffe_pkg::*; #(
   parameter int PANEL_WIDTH  = 1024,
   parameter int PANEL_HEIGHT = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   // front to queue
   queue_wr_type q_wr;
   op_type       q_op;
   logic         q_full;

   // queue to back
   logic         q_empty;
   logic         q_pop;
   op_type       q_head;

   // back end still initializing the store
   logic         init_busy;

   // command decode, frame banding and clipping
   mrffe_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .init_busy(init_busy),
      .q_wr     (q_wr),
      .q_full   (q_full),
      .q_op     (q_op)
   );

   // decouples command intake from the store walk
   mrffe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .q_wr (q_wr),
      .wr_op(q_op),
      .full (q_full),
      .pop  (q_pop),
      .empty(q_empty),
      .head (q_head)
   );

   // store walk and result transaction
   mrffe_back #(
      .PANEL_WIDTH(PANEL_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .init_busy(init_busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

endmodule
